FILE: sv/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants for the keypad calculator
// Key codes, operation codes, the microcode word and its program table.
// ----------------------------------------------------------------------------
package kfc_pkg;

   // Fixed result field widths
   localparam int INT_W  = 27;
   localparam int FRAC_W = 16;

   // Key codes
   localparam logic [7:0] KEY_DIGIT_MAX = 8'd9;
   localparam logic [7:0] KEY_ADD       = 8'h2B;
   localparam logic [7:0] KEY_SUB       = 8'h2D;
   localparam logic [7:0] KEY_MUL       = 8'h2A;
   localparam logic [7:0] KEY_DIV       = 8'h2F;
   localparam logic [7:0] KEY_EQ        = 8'h3D;
   localparam logic [7:0] KEY_CLR       = 8'h43;

   localparam int DEC_BASE = 10;

   // Pending operation
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   // Datapath micro-operations
   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_DIGIT,
      UOP_OPER,
      UOP_CLRCNT,
      UOP_DIV_INIT,
      UOP_DIV_STEP,
      UOP_DIV_DONE,
      UOP_ADD,
      UOP_SUB,
      UOP_MUL,
      UOP_DZ,
      UOP_EMIT,
      UOP_CLRALL
   } uop_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_OP_NONE,
      COND_OP_ADD,
      COND_OP_SUB,
      COND_OP_MUL,
      COND_B_ZERO,
      COND_OUT_BUSY
   } cond_type;

   localparam int UA_W = 5;
   typedef logic [UA_W-1:0] uaddr_type;

   // Program addresses
   localparam uaddr_type UA_DIGIT   = 5'd0;
   localparam uaddr_type UA_OPER    = 5'd1;
   localparam uaddr_type UA_CLEAR   = 5'd2;
   localparam uaddr_type UA_EQ      = 5'd3;
   localparam uaddr_type UA_EQ_ADD  = 5'd4;
   localparam uaddr_type UA_EQ_SUB  = 5'd5;
   localparam uaddr_type UA_EQ_MUL  = 5'd6;
   localparam uaddr_type UA_EQ_DIV  = 5'd7;
   localparam uaddr_type UA_DIVINIT = 5'd8;
   localparam uaddr_type UA_DIVLOOP = 5'd9;
   localparam uaddr_type UA_DIVDONE = 5'd10;
   localparam uaddr_type UA_ADD     = 5'd11;
   localparam uaddr_type UA_SUB     = 5'd12;
   localparam uaddr_type UA_MUL     = 5'd13;
   localparam uaddr_type UA_DZ      = 5'd14;
   localparam uaddr_type UA_EMIT    = 5'd15;
   localparam uaddr_type UA_CLRALL  = 5'd16;

   // One control word; div_loop repeats the step while the iteration count runs
   typedef struct packed {
      uop_type   uop;
      cond_type  cond;
      logic      div_loop;
      uaddr_type target;
      logic      last;
   } uword_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic op_none;
      logic op_add;
      logic op_sub;
      logic op_mul;
      logic b_zero;
      logic div_more;
      logic out_busy;
   } status_type;

   // Entry point for an accepted key
   typedef struct packed {
      logic      valid;
      uaddr_type addr;
   } entry_type;

   function automatic int dec_width(input int n);
      int p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * DEC_BASE;
      return $clog2(p);
   endfunction

   function automatic entry_type key_entry(input logic [7:0] key);
      entry_type e;
      e.valid = 1'b1;
      e.addr  = UA_DIGIT;
      if (key <= KEY_DIGIT_MAX) e.addr = UA_DIGIT;
      else if (key == KEY_ADD || key == KEY_SUB || key == KEY_MUL || key == KEY_DIV)
         e.addr = UA_OPER;
      else if (key == KEY_CLR) e.addr = UA_CLEAR;
      else if (key == KEY_EQ) e.addr = UA_EQ;
      else e.valid = 1'b0;
      return e;
   endfunction

   function automatic op_type key_to_op(input logic [7:0] key);
      op_type o;
      unique case (key)
         KEY_ADD: o = OP_ADD;
         KEY_SUB: o = OP_SUB;
         KEY_MUL: o = OP_MUL;
         KEY_DIV: o = OP_DIV;
         default: o = OP_NONE;
      endcase
      return o;
   endfunction

   function automatic uword_type mk(input uop_type u, input cond_type c,
                                    input uaddr_type t, input logic l);
      uword_type w;
      w.uop      = u;
      w.cond     = c;
      w.div_loop = 1'b0;
      w.target   = t;
      w.last     = l;
      return w;
   endfunction

   // Microcode program
   function automatic uword_type ucode_rom(input uaddr_type a);
      uword_type w;
      unique case (a)
         UA_DIGIT:   w = mk(UOP_DIGIT,    COND_NEVER,    UA_DIGIT,   1'b1);
         UA_OPER:    w = mk(UOP_OPER,     COND_NEVER,    UA_DIGIT,   1'b1);
         UA_CLEAR:   w = mk(UOP_CLRCNT,   COND_NEVER,    UA_DIGIT,   1'b1);
         UA_EQ:      w = mk(UOP_NOP,      COND_OP_NONE,  UA_CLRALL,  1'b0);
         UA_EQ_ADD:  w = mk(UOP_NOP,      COND_OP_ADD,   UA_ADD,     1'b0);
         UA_EQ_SUB:  w = mk(UOP_NOP,      COND_OP_SUB,   UA_SUB,     1'b0);
         UA_EQ_MUL:  w = mk(UOP_NOP,      COND_OP_MUL,   UA_MUL,     1'b0);
         UA_EQ_DIV:  w = mk(UOP_NOP,      COND_B_ZERO,   UA_DZ,      1'b0);
         UA_DIVINIT: w = mk(UOP_DIV_INIT, COND_NEVER,    UA_DIGIT,   1'b0);
         UA_DIVLOOP: begin
            w = mk(UOP_DIV_STEP, COND_NEVER, UA_DIVLOOP, 1'b0);
            w.div_loop = 1'b1;
         end
         UA_DIVDONE: w = mk(UOP_DIV_DONE, COND_ALWAYS,   UA_EMIT,    1'b0);
         UA_ADD:     w = mk(UOP_ADD,      COND_ALWAYS,   UA_EMIT,    1'b0);
         UA_SUB:     w = mk(UOP_SUB,      COND_ALWAYS,   UA_EMIT,    1'b0);
         UA_MUL:     w = mk(UOP_MUL,      COND_ALWAYS,   UA_EMIT,    1'b0);
         UA_DZ:      w = mk(UOP_DZ,       COND_NEVER,    UA_DIGIT,   1'b0);
         UA_EMIT:    w = mk(UOP_EMIT,     COND_OUT_BUSY, UA_EMIT,    1'b0);
         UA_CLRALL:  w = mk(UOP_CLRALL,   COND_NEVER,    UA_DIGIT,   1'b1);
         default:    w = mk(UOP_NOP,      COND_NEVER,    UA_DIGIT,   1'b1);
      endcase
      return w;
   endfunction

endpackage

FILE: sv/kfc_seq.sv
// ----------------------------------------------------------------------------
// kfc_seq: microcode sequencer
// Step counter over the program table with conditional jumps.
// ----------------------------------------------------------------------------
module kfc_seq
   import kfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  entry_type  entry,
   input  status_type status,
   output logic       busy,
   output uop_type    uop
);

   logic      busy_ff, busy_in;
   uaddr_type pc_ff, pc_in;
   uword_type word;
   logic      taken;

   assign word = ucode_rom(pc_ff);
   assign busy = busy_ff;
   assign uop  = busy_ff ? word.uop : UOP_NOP;

   // Jump condition select
   always_comb begin
      unique case (word.cond)
         COND_NEVER:    taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_OP_NONE:  taken = status.op_none;
         COND_OP_ADD:   taken = status.op_add;
         COND_OP_SUB:   taken = status.op_sub;
         COND_OP_MUL:   taken = status.op_mul;
         COND_B_ZERO:   taken = status.b_zero;
         COND_OUT_BUSY: taken = status.out_busy;
         default:       taken = 1'b0;
      endcase
      if (word.div_loop) taken = status.div_more;
   end

   // Next step
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (start && entry.valid) begin
            busy_in = 1'b1;
            pc_in   = entry.addr;
         end
      end else if (taken) begin
         pc_in = word.target;
      end else if (word.last) begin
         busy_in = 1'b0;
      end else begin
         pc_in = pc_ff + uaddr_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= UA_DIGIT;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

FILE: sv/kfc_dp.sv
// ----------------------------------------------------------------------------
// kfc_dp: calculator datapath
// Operand registers, add/subtract/multiply, bit-serial divider, result register.
// ----------------------------------------------------------------------------
module kfc_dp
   import kfc_pkg::*;
#(
   parameter int MAX_DIGITS = 4,
   parameter int FRAC_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic [7:0]        req_key,
   input  uop_type           uop,
   output status_type        status,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [INT_W-1:0]  rsp_int,
   output logic [FRAC_W-1:0] rsp_frac,
   output logic              rsp_neg,
   output logic              rsp_dz
);

   localparam int OPW  = dec_width(MAX_DIGITS);
   localparam int CNTW = $clog2(MAX_DIGITS + 1);
   localparam int QW   = OPW + FRAC_BITS;
   localparam int ITW  = $clog2(QW + 1);

   // Architectural state
   logic [OPW-1:0]  a_ff, a_in, b_ff, b_in;
   op_type          op_ff, op_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [7:0]        key_ff;
   logic [OPW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [ITW-1:0]    it_ff, it_in;
   logic [INT_W-1:0]  res_int_ff, res_int_in, rsp_int_ff, rsp_int_in;
   logic [FRAC_W-1:0] res_frac_ff, res_frac_in, rsp_frac_ff, rsp_frac_in;
   logic              res_neg_ff, res_neg_in, rsp_neg_ff, rsp_neg_in;
   logic              res_dz_ff, res_dz_in, rsp_dz_ff, rsp_dz_in;

   logic              out_busy;
   logic [OPW:0]      trial, diff;
   logic              ge;
   logic [2*OPW-1:0]  prod;
   logic [OPW:0]      sum;
   logic [OPW-1:0]    digit_ext;
   logic [FRAC_BITS-1:0] frac_full;

   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign trial     = {rem_ff, quo_ff[QW-1]};
   assign diff      = trial - {1'b0, b_ff};
   assign ge        = trial >= {1'b0, b_ff};
   assign prod      = a_ff * b_ff;
   assign sum       = {1'b0, a_ff} + {1'b0, b_ff};
   assign digit_ext = OPW'(key_ff[3:0]);
   assign frac_full = quo_ff[FRAC_BITS-1:0];

   assign status.op_none  = (op_ff == OP_NONE);
   assign status.op_add   = (op_ff == OP_ADD);
   assign status.op_sub   = (op_ff == OP_SUB);
   assign status.op_mul   = (op_ff == OP_MUL);
   assign status.b_zero   = (b_ff == '0);
   assign status.div_more = (it_ff != ITW'(1));
   assign status.out_busy = out_busy;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_int   = rsp_int_ff;
   assign rsp_frac  = rsp_frac_ff;
   assign rsp_neg   = rsp_neg_ff;
   assign rsp_dz    = rsp_dz_ff;

   // Micro-operation decode
   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      it_in        = it_ff;
      res_int_in   = res_int_ff;
      res_frac_in  = res_frac_ff;
      res_neg_in   = res_neg_ff;
      res_dz_in    = res_dz_ff;
      rsp_int_in   = rsp_int_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_dz_in    = rsp_dz_ff;
      rsp_valid_in = out_busy;
      unique case (uop)
         UOP_NOP: ;
         UOP_DIGIT: begin
            // digits past the limit are dropped, count stays saturated
            if (cnt_ff < CNTW'(MAX_DIGITS)) begin
               if (cnt_ff == '0) b_in = digit_ext;
               else b_in = OPW'(b_ff * OPW'(DEC_BASE)) + digit_ext;
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         UOP_OPER: begin
            cnt_in = '0;
            a_in   = b_ff;
            op_in  = key_to_op(key_ff);
         end
         UOP_CLRCNT: cnt_in = '0;
         UOP_DIV_INIT: begin
            rem_in = '0;
            quo_in = QW'(a_ff) << FRAC_BITS;
            it_in  = ITW'(QW);
         end
         UOP_DIV_STEP: begin
            // restoring division, one quotient bit per step
            rem_in = ge ? diff[OPW-1:0] : trial[OPW-1:0];
            quo_in = {quo_ff[QW-2:0], ge};
            it_in  = it_ff - ITW'(1);
         end
         UOP_DIV_DONE: begin
            res_int_in  = INT_W'(quo_ff >> FRAC_BITS);
            res_frac_in = FRAC_W'(frac_full);
            res_neg_in  = 1'b0;
            res_dz_in   = 1'b0;
         end
         UOP_ADD: begin
            res_int_in  = INT_W'(sum);
            res_frac_in = '0;
            res_neg_in  = 1'b0;
            res_dz_in   = 1'b0;
         end
         UOP_SUB: begin
            res_int_in  = (a_ff >= b_ff) ? INT_W'(a_ff - b_ff) : INT_W'(b_ff - a_ff);
            res_frac_in = '0;
            res_neg_in  = (a_ff < b_ff);
            res_dz_in   = 1'b0;
         end
         UOP_MUL: begin
            res_int_in  = INT_W'(prod);
            res_frac_in = '0;
            res_neg_in  = 1'b0;
            res_dz_in   = 1'b0;
         end
         UOP_DZ: begin
            res_int_in  = '0;
            res_frac_in = '0;
            res_neg_in  = 1'b0;
            res_dz_in   = 1'b1;
         end
         UOP_EMIT: begin
            // load the output register once it is free
            if (!out_busy) begin
               rsp_int_in   = res_int_ff;
               rsp_frac_in  = res_frac_ff;
               rsp_neg_in   = res_neg_ff;
               rsp_dz_in    = res_dz_ff;
               rsp_valid_in = 1'b1;
            end
         end
         UOP_CLRALL: begin
            a_in   = '0;
            b_in   = '0;
            op_in  = OP_NONE;
            cnt_in = '0;
         end
         default: ;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= '0;
         b_ff         <= '0;
         op_ff        <= OP_NONE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_ff         <= a_in;
         b_ff         <= b_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) key_ff <= req_key;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      it_ff       <= it_in;
      res_int_ff  <= res_int_in;
      res_frac_ff <= res_frac_in;
      res_neg_ff  <= res_neg_in;
      res_dz_ff   <= res_dz_in;
      rsp_int_ff  <= rsp_int_in;
      rsp_frac_ff <= rsp_frac_in;
      rsp_neg_ff  <= rsp_neg_in;
      rsp_dz_ff   <= rsp_dz_in;
   end

endmodule

FILE: sv/keypad_four_function_calculator.sv
// ----------------------------------------------------------------------------
// keypad_four_function_calculator: four-function keypad calculator
// Digit, operator, clear and equals keys drive a microcoded datapath.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req      in         req_valid/req_ready    req_key_code[7:0]
//  rsp      out        rsp_valid/rsp_ready    rsp_int_part, rsp_frac_part,
//                                             rsp_negative, rsp_div_by_zero
//
//  One request at a time: req_ready stays low while a key's program runs.
//  Digit, operator and clear keys run one step; unknown keys run none.
//  '=' runs 2 steps with nothing pending, 5 to 8 for add, subtract, multiply
//  and divide by zero, and 9 plus one per quotient bit for division: operand
//  bits (14 at four digits) plus FRAC_BITS, 39 steps by default.
//  A full output register holds the emit step until rsp_ready frees it.
//  Synchronous reset clears operands, pending operation and digit count.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator
   import kfc_pkg::*;
#(
   parameter int MAX_DIGITS = 4,
   parameter int FRAC_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_key_code,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [INT_W-1:0]  rsp_int_part,
   output logic [FRAC_W-1:0] rsp_frac_part,
   output logic              rsp_negative,
   output logic              rsp_div_by_zero
);

   logic       busy;
   logic       req_fire;
   uop_type    uop;
   status_type status;

   assign req_ready = !busy;
   assign req_fire  = req_valid && req_ready;

   // Program sequencer
   kfc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire),
      .entry  (key_entry(req_key_code)),
      .status (status),
      .busy   (busy),
      .uop    (uop)
   );

   // Datapath and result register
   kfc_dp #(
      .MAX_DIGITS (MAX_DIGITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_key   (req_key_code),
      .uop       (uop),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_int   (rsp_int_part),
      .rsp_frac  (rsp_frac_part),
      .rsp_neg   (rsp_negative),
      .rsp_dz    (rsp_div_by_zero)
   );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for keypad_four_function_calculator
// A directed key table, then random key sequences, mostly well-formed
// calculations with some noise. Every accepted request runs through a local
// calculator model. Each result is compared field by field with the oldest
// result still due. Both handshakes idle in random bursts, and there is one
// long stall on the result side.
// ----------------------------------------------------------------------------
module tb_top;
   import kfc_pkg::*;

   localparam int DIGIT_LIMIT = 4;
   localparam int ITEM_TOTAL  = 1150;
   localparam int CALM_ITEMS  = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 100;
   localparam int DIR_COUNT   = 26;

   typedef struct packed {
      logic [INT_W-1:0]  int_part;
      logic [FRAC_W-1:0] frac_part;
      logic              negative;
      logic              div_by_zero;
   } calc_result_type;

   typedef struct packed {
      logic [7:0]      key;
      logic            typed;
      calc_result_type res;
   } dir_row_type;

   // Directed keys; typed results only where the answer is obvious
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{KEY_EQ,  1'b0, '0},
      '{8'd9,    1'b0, '0},
      '{8'd9,    1'b0, '0},
      '{8'd9,    1'b0, '0},
      '{8'd9,    1'b0, '0},
      '{8'd9,    1'b0, '0},
      '{KEY_MUL, 1'b0, '0},
      '{KEY_EQ,  1'b1, '{27'd99980001, 16'd0, 1'b0, 1'b0}},
      '{KEY_DIV, 1'b0, '0},
      '{KEY_EQ,  1'b1, '{27'd0, 16'd0, 1'b0, 1'b1}},
      '{8'd0,    1'b0, '0},
      '{KEY_SUB, 1'b0, '0},
      '{8'd1,    1'b0, '0},
      '{KEY_EQ,  1'b1, '{27'd1, 16'd0, 1'b1, 1'b0}},
      '{8'd7,    1'b0, '0},
      '{KEY_ADD, 1'b0, '0},
      '{KEY_SUB, 1'b0, '0},
      '{8'd3,    1'b0, '0},
      '{KEY_EQ,  1'b0, '0},
      '{8'd1,    1'b0, '0},
      '{KEY_CLR, 1'b0, '0},
      '{8'd5,    1'b0, '0},
      '{KEY_DIV, 1'b0, '0},
      '{8'h0A,   1'b0, '0},
      '{8'd3,    1'b0, '0},
      '{KEY_EQ,  1'b0, '0}
   };

   localparam logic [7:0] OP_KEYS [4] = '{KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_key_code = 8'd0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [INT_W-1:0]  rsp_int_part;
   logic [FRAC_W-1:0] rsp_frac_part;
   logic              rsp_negative;
   logic              rsp_div_by_zero;

   // Calculator model state
   logic [13:0] acc_first;
   logic [13:0] acc_second;
   op_type      acc_op;
   logic [2:0]  acc_digits;

   calc_result_type results_due [$];
   int           errors      = 0;
   int           items_sent  = 0;
   bit           tx_idle_on  = 1'b1;
   bit           rx_idle_on  = 1'b1;
   bit           hold_req    = 1'b0;

   keypad_four_function_calculator #(
      .MAX_DIGITS(DIGIT_LIMIT),
      .FRAC_BITS (FRAC_W)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_code   (req_key_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_int_part   (rsp_int_part),
      .rsp_frac_part  (rsp_frac_part),
      .rsp_negative   (rsp_negative),
      .rsp_div_by_zero(rsp_div_by_zero)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("ERROR @%0t: %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Apply one key to the calculator model; returns 1 when '=' yields a result
   function automatic bit calc_key(input logic [7:0] k, output calc_result_type r);
      longint unsigned quo;
      bit              emit;
      r    = '0;
      emit = 1'b0;
      if (k <= KEY_DIGIT_MAX) begin
         // digits past the limit are dropped
         if (acc_digits < DIGIT_LIMIT) begin
            if (acc_digits == 3'd0) acc_second = 14'(k);
            else acc_second = 14'(32'(acc_second) * DEC_BASE + 32'(k));
            acc_digits++;
         end
      end else begin
         case (k) inside
            KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
               acc_digits = 3'd0;
               acc_first  = acc_second;
               acc_op     = (k == KEY_ADD) ? OP_ADD :
                            (k == KEY_SUB) ? OP_SUB :
                            (k == KEY_MUL) ? OP_MUL : OP_DIV;
            end
            KEY_CLR: acc_digits = 3'd0;
            KEY_EQ: begin
               emit = 1'b1;
               case (acc_op)
                  OP_ADD: r.int_part = INT_W'(32'(acc_first) + 32'(acc_second));
                  OP_SUB: begin
                     if (acc_first >= acc_second) begin
                        r.int_part = INT_W'(32'(acc_first) - 32'(acc_second));
                     end else begin
                        r.int_part = INT_W'(32'(acc_second) - 32'(acc_first));
                        r.negative = 1'b1;
                     end
                  end
                  OP_MUL: r.int_part = INT_W'(32'(acc_first) * 32'(acc_second));
                  OP_DIV: begin
                     if (acc_second == 14'd0) begin
                        r.div_by_zero = 1'b1;
                     end else begin
                        quo = (64'(acc_first) << FRAC_W) / 64'(acc_second);
                        r.int_part  = INT_W'(quo >> FRAC_W);
                        r.frac_part = FRAC_W'(quo);
                     end
                  end
                  default: emit = 1'b0;
               endcase
               // '=' always clears everything
               acc_first  = '0;
               acc_second = '0;
               acc_op     = OP_NONE;
               acc_digits = '0;
            end
            default: ;
         endcase
      end
      return emit;
   endfunction

   // Offer one request, wait for acceptance, then log what it should produce
   task automatic send_key(input logic [7:0] k, input bit typed,
                           input calc_result_type typed_res);
      calc_result_type r;
      int              gap;
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_key_code <= k;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (calc_key(k, r)) results_due.push_back(typed ? typed_res : r);
   endtask

   // Random digits for one operand
   task automatic send_digits(input int n);
      for (int i = 0; i < n; i++) send_key(8'($urandom_range(0, 9)), 1'b0, '0);
   endtask

   // One random key sequence: mostly a full calculation, sometimes noise
   task automatic run_sequence();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 4)) send_key(8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
         send_digits($urandom_range(0, 5));
         send_key(OP_KEYS[$urandom_range(0, 3)], 1'b0, '0);
         if ($urandom_range(0, 9) == 0)
            send_key(OP_KEYS[$urandom_range(0, 3)], 1'b0, '0);
         if ($urandom_range(0, 6) == 0) begin
            send_key(8'd0, 1'b0, '0);
         end else begin
            send_digits($urandom_range(0, 5));
         end
         if ($urandom_range(0, 9) == 0) begin
            send_key(KEY_CLR, 1'b0, '0);
            send_digits($urandom_range(0, 3));
         end
         if ($urandom_range(0, 9) == 0)
            send_key(8'($urandom_range(0, 255)), 1'b0, '0);
         if ($urandom_range(0, 19) != 0) send_key(KEY_EQ, 1'b0, '0);
      end
   endtask

   // Result side ready: random bursts low, one long hold-off on request
   initial begin
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result checker
   always @(posedge clock) begin : rsp_check
      calc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch("result with none due, int_part", rsp_int_part, 0);
         end else begin
            want = results_due.pop_front();
            if (rsp_int_part !== want.int_part)
               report_mismatch("int_part", rsp_int_part, want.int_part);
            if (rsp_frac_part !== want.frac_part)
               report_mismatch("frac_part", rsp_frac_part, want.frac_part);
            if (rsp_negative !== want.negative)
               report_mismatch("negative", rsp_negative, want.negative);
            if (rsp_div_by_zero !== want.div_by_zero)
               report_mismatch("div_by_zero", rsp_div_by_zero, want.div_by_zero);
         end
      end
   end

   // Main stimulus
   initial begin
      int seq_no;
      acc_first  = '0;
      acc_second = '0;
      acc_op     = OP_NONE;
      acc_digits = '0;
      seq_no     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIR_COUNT; i++)
         send_key(DIR_ROWS[i].key, DIR_ROWS[i].typed, DIR_ROWS[i].res);

      // sender pause: let every result due come out
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);

      // random sequences; the tail runs without idling
      while (items_sent < ITEM_TOTAL) begin
         if (items_sent > ITEM_TOTAL - CALM_ITEMS) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         if (seq_no == 15) hold_req = 1'b1;
         run_sequence();
         seq_no++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && results_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #6_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
